>>> rtl/core/macsec_in_gre_mpls_parser_stats_macros.svh
// Assertion macros used by the parser statistics RTL
`ifndef MACSEC_IN_GRE_MPLS_PARSER_STATS_MACROS_SVH
`define MACSEC_IN_GRE_MPLS_PARSER_STATS_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define MIMPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mimps assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define MIMPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mimps assertion failed");

`endif

>>> rtl/core/mimps_pkg.sv
// Shared types and constants for the MACsec-in-GRE/MPLS parser statistics block
`default_nettype none

package mimps_pkg;

  localparam int unsigned CounterWidthDefault = 64;
  localparam int unsigned CountOutWidth       = 64;
  localparam int unsigned PosWidth            = 7;

  // Byte positions (without control word)
  localparam logic [PosWidth-1:0] PosMax       = 7'd127;
  localparam logic [PosWidth-1:0] PosEthTypeHi = 7'd12;
  localparam logic [PosWidth-1:0] PosEthTypeLo = 7'd13;
  localparam logic [PosWidth-1:0] PosIpProto   = 7'd23;
  localparam logic [PosWidth-1:0] PosGreProtHi = 7'd36;
  localparam logic [PosWidth-1:0] PosGreProtLo = 7'd37;
  localparam logic [PosWidth-1:0] PosInnerType = 7'd54;
  localparam logic [PosWidth-1:0] PosPnStart   = 7'd58;
  localparam logic [PosWidth-1:0] PosSciStart  = 7'd62;
  localparam logic [PosWidth-1:0] PosMinLast   = 7'd71;
  localparam logic [PosWidth-1:0] PnBytes      = 7'd4;
  localparam logic [PosWidth-1:0] SciBytes     = 7'd8;
  localparam logic [PosWidth-1:0] CtrlWordLen  = 7'd4;

  // Expected byte values
  localparam logic [7:0] EthIpv4Hi   = 8'h08;
  localparam logic [7:0] EthIpv4Lo   = 8'h00;
  localparam logic [7:0] IpProtoGre  = 8'd47;
  localparam logic [7:0] GreMplsHi   = 8'h88;
  localparam logic [7:0] GreMplsLo   = 8'h47;
  localparam logic [7:0] EthMacsecHi = 8'h88;
  localparam logic [7:0] EthMacsecLo = 8'hE5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_packet;
    logic [5:0] ingress_port;
  } in_t;

  typedef struct packed {
    logic        matched;
    logic [31:0] macsec_pn;
    logic [63:0] channel_id;
    logic [5:0]  port_out;
    logic [63:0] all_packets;
    logic [63:0] matching_packets;
    logic [31:0] highest_number;
  } out_t;

  // Byte leaving the input register this cycle
  typedef struct packed {
    logic fire;
    in_t  item;
  } step_t;

  // Per-packet verdict, meaningful when done is set
  typedef struct packed {
    logic        done;
    logic        matched;
    logic [31:0] pn;
    logic [63:0] sci;
    logic [5:0]  port;
  } verdict_t;

endpackage

`default_nettype wire

>>> rtl/core/macsec_in_gre_mpls_parser_stats.sv
// Throughput: one byte per cycle; only a final byte waits, for a free result register.
// A result becomes valid once its final byte has passed through the input register
// and its verdict has been loaded into the result register.
// Per-packet state advances one byte per cycle through the input register stage.
// Reset (rst_ni low, asynchronous) clears counters, per-packet state, the
// control-word register and both valid flags; no clearing pass is needed.
`default_nettype none

`include "macsec_in_gre_mpls_parser_stats_macros.svh"

module macsec_in_gre_mpls_parser_stats #(
  parameter int unsigned COUNTER_WIDTH = mimps_pkg::CounterWidthDefault
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic            cfg_wdata_i,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire mimps_pkg::in_t  in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output mimps_pkg::out_t      out_data_o
);
  import mimps_pkg::*;

  // Control-word register: when set, every offset after the MPLS label moves up by
  // four bytes. The user must write it only while the block is idle (not enforced).
  logic     cw_present_q;

  step_t    step;
  verdict_t verdict;
  logic     slot_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cw_present_q <= 1'b0;
    end else if (cfg_we_i) begin
      cw_present_q <= cfg_wdata_i;
    end
  end

  // Hold each byte in the input register; advance it when the result side
  // has room or when it is not the final byte of a packet.
  mimps_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .slot_free_i (slot_free),
    .step_o      (step)
  );

  // Check header bytes against the expected layering and shift in the
  // packet number and SCI as their bytes go past.
  mimps_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cw_present_i (cw_present_q),
    .step_i       (step),
    .verdict_o    (verdict)
  );

  // Update the wrapping counters and the highest packet number, then
  // register the transaction for the output channel.
  mimps_stats #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_stats (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .verdict_i   (verdict),
    .slot_free_o (slot_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Unmatched results carry no packet number or SCI
  `MIMPS_ASSERT_NOW(a_unmatched_zero, clk_i, rst_ni,
    out_valid_o && !out_data_o.matched,
    out_data_o.macsec_pn == 32'd0 && out_data_o.channel_id == 64'd0)

  // The running maximum never falls below the packet number reported with it
  `MIMPS_ASSERT_NOW(a_highest_bound, clk_i, rst_ni,
    out_valid_o && out_data_o.matched,
    out_data_o.highest_number >= out_data_o.macsec_pn)

  // A final byte that leaves the input register always produces a transaction
  `MIMPS_ASSERT_NEXT(a_final_byte_result, clk_i, rst_ni,
    verdict.done,
    out_valid_o)

endmodule

`default_nettype wire

>>> rtl/core/mimps_in_stage.sv
// Input register stage for the byte stream
`default_nettype none

module mimps_in_stage (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire mimps_pkg::in_t in_data_i,
  input  wire logic          slot_free_i,
  output mimps_pkg::step_t   step_o
);
  import mimps_pkg::*;

  logic valid_q;
  in_t  data_q;
  logic advance;

  // A final byte needs room in the result register; other bytes always move
  assign advance    = valid_q && (!data_q.end_of_packet || slot_free_i);
  assign in_ready_o = !valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= in_data_i;
    end
  end

  assign step_o.fire = advance;
  assign step_o.item = data_q;

endmodule

`default_nettype wire

>>> rtl/core/mimps_parser.sv
// Per-packet header checker and PN/SCI capture
`default_nettype none

module mimps_parser (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cw_present_i,
  input  wire mimps_pkg::step_t  step_i,
  output mimps_pkg::verdict_t    verdict_o
);
  import mimps_pkg::*;

  logic [PosWidth-1:0] pos_q, pos_d;
  logic                ok_q, ok_d;
  logic [31:0]         pn_q, pn_d;
  logic [63:0]         sci_q, sci_d;

  logic [PosWidth-1:0] shift;
  logic [PosWidth-1:0] inner_pos, pn_pos, sci_pos, min_last;
  logic [7:0]          b;
  logic                byte_ok;
  logic                ok_now;
  logic                pn_hit, sci_hit;

  assign b         = step_i.item.data_byte;
  assign shift     = cw_present_i ? CtrlWordLen : '0;
  assign inner_pos = PosInnerType + shift;
  assign pn_pos    = PosPnStart + shift;
  assign sci_pos   = PosSciStart + shift;
  assign min_last  = PosMinLast + shift;

  always_comb begin
    byte_ok = 1'b1;
    if (pos_q == PosEthTypeHi)                  byte_ok = (b == EthIpv4Hi);
    else if (pos_q == PosEthTypeLo)             byte_ok = (b == EthIpv4Lo);
    else if (pos_q == PosIpProto)               byte_ok = (b == IpProtoGre);
    else if (pos_q == PosGreProtHi)             byte_ok = (b == GreMplsHi);
    else if (pos_q == PosGreProtLo)             byte_ok = (b == GreMplsLo);
    else if (pos_q == inner_pos)                byte_ok = (b == EthMacsecHi);
    else if (pos_q == inner_pos + 7'd1)         byte_ok = (b == EthMacsecLo);
  end

  assign ok_now  = ok_q && byte_ok;
  assign pn_hit  = (pos_q >= pn_pos) && (pos_q < pn_pos + PnBytes);
  assign sci_hit = (pos_q >= sci_pos) && (pos_q < sci_pos + SciBytes);
  assign pn_d    = pn_hit  ? {pn_q[23:0], b}  : pn_q;
  assign sci_d   = sci_hit ? {sci_q[55:0], b} : sci_q;
  assign ok_d    = ok_now;
  assign pos_d   = (pos_q == PosMax) ? pos_q : pos_q + 7'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      ok_q  <= 1'b1;
      pn_q  <= '0;
      sci_q <= '0;
    end else if (step_i.fire) begin
      if (step_i.item.end_of_packet) begin
        pos_q <= '0;
        ok_q  <= 1'b1;
        pn_q  <= '0;
        sci_q <= '0;
      end else begin
        pos_q <= pos_d;
        ok_q  <= ok_d;
        pn_q  <= pn_d;
        sci_q <= sci_d;
      end
    end
  end

  assign verdict_o.done    = step_i.fire && step_i.item.end_of_packet;
  assign verdict_o.matched = ok_now && (pos_q >= min_last);
  assign verdict_o.pn      = pn_d;
  assign verdict_o.sci     = sci_d;
  assign verdict_o.port    = step_i.item.ingress_port;

endmodule

`default_nettype wire

>>> rtl/core/mimps_stats.sv
// Running counters and result register
`default_nettype none

module mimps_stats #(
  parameter int unsigned COUNTER_WIDTH = mimps_pkg::CounterWidthDefault
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire mimps_pkg::verdict_t  verdict_i,
  output logic                      slot_free_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output mimps_pkg::out_t           out_data_o
);
  import mimps_pkg::*;

  logic [COUNTER_WIDTH-1:0] total_q, total_d;
  logic [COUNTER_WIDTH-1:0] match_q, match_d;
  logic [31:0]              high_q, high_d;
  logic                     valid_q;
  out_t                     out_q, out_d;

  assign slot_free_o = !valid_q || out_ready_i;

  always_comb begin
    total_d = total_q + COUNTER_WIDTH'(1);
    match_d = match_q;
    high_d  = high_q;
    if (verdict_i.matched) begin
      match_d = match_q + COUNTER_WIDTH'(1);
      if (verdict_i.pn > high_q) high_d = verdict_i.pn;
    end
    out_d.matched          = verdict_i.matched;
    out_d.macsec_pn        = verdict_i.matched ? verdict_i.pn  : '0;
    out_d.channel_id       = verdict_i.matched ? verdict_i.sci : '0;
    out_d.port_out         = verdict_i.port;
    out_d.all_packets      = CountOutWidth'(total_d);
    out_d.matching_packets = CountOutWidth'(match_d);
    out_d.highest_number   = high_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      match_q <= '0;
      high_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      if (verdict_i.done) begin
        total_q <= total_d;
        match_q <= match_d;
        high_q  <= high_d;
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (verdict_i.done) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
